### design/ftsched_pkg.sv
// Shared constants, types and state machine codes of the fixed-step tick scheduler.
// Used by ftsched_ctrl, ftsched_dp and fixed_step_tick_scheduler; depends on nothing.
`default_nettype none

package ftsched_pkg;

  // Field widths.
  localparam int unsigned FT_W   = 32;  // frame time, 2^-24 s
  localparam int unsigned TS_W   = 24;  // time scale, Q8.16
  localparam int unsigned TI_W   = 32;  // tick interval
  localparam int unsigned MS_W   = 8;   // step cap
  localparam int unsigned PROD_W = FT_W + TS_W;
  localparam int unsigned SIM_W  = 40;
  localparam int unsigned SUM_W  = SIM_W + 1;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned QUO_W  = SUM_W + FRAC_W;
  localparam int unsigned REQ_W  = 34;
  localparam int unsigned ALPHA_W = FRAC_W + 1;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned LREQ_W = TS_W + 1 - FRAC_W;

  // Pacing constants.
  localparam int unsigned LOCKSTEP_CAP = 5;
  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned FT_KEEP      = (TIME_BITS < FT_W) ? TIME_BITS : FT_W;
  localparam logic [FT_W-1:0] FT_MASK  = FT_W'((64'd1 << FT_KEEP) - 64'd1);

  localparam logic [REQ_W-1:0]   TICK_MAX  = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

  // Serial divider sequencing.
  localparam int unsigned STEP_W    = 6;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned REM_STEP  = SUM_W;

  // Register map.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_TICK_INTERVAL = 1'b0;
  localparam logic REG_MAX_STEPS     = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_MUL2,
    S_DIV,
    S_WRAP,
    S_TOTAL,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    ROUTE_FINISH,
    ROUTE_TICKS,
    ROUTE_DIVIDE
  } route_e;

  typedef struct packed {
    logic capture;
    logic mul_scale;
    logic mul_tick;
    logic prep;
    logic div_step;
    logic latch_rem;
    logic wrap;
    logic totals;
    logic sim_lo;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    route_e route;
    logic   out_free;
  } stat_t;

endpackage

`default_nettype wire

### design/ftsched_ctrl.sv
// Sequencer of the fixed-step tick scheduler: accepts a frame, steps the datapath
// through multiply, division and bookkeeping, and hands off the result. Uses ftsched_pkg.
`default_nettype none

module ftsched_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ftsched_pkg::stat_t stat_i,
  output ftsched_pkg::cmd_t       cmd_o
);

  ftsched_pkg::state_e state_q, state_d;
  logic [ftsched_pkg::STEP_W-1:0] step_q, step_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftsched_pkg::S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ftsched_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ftsched_pkg::S_MUL;
        end
      end
      ftsched_pkg::S_MUL: begin
        cmd_o.mul_scale = 1'b1;
        state_d         = ftsched_pkg::S_PREP;
      end
      ftsched_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        step_d     = '0;
        unique case (stat_i.route)
          ftsched_pkg::ROUTE_TICKS:  state_d = ftsched_pkg::S_MUL2;
          ftsched_pkg::ROUTE_DIVIDE: state_d = ftsched_pkg::S_DIV;
          default:                   state_d = ftsched_pkg::S_TOTAL;
        endcase
      end
      ftsched_pkg::S_MUL2: begin
        cmd_o.mul_tick = 1'b1;
        state_d        = ftsched_pkg::S_TOTAL;
      end
      ftsched_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        // After the whole-tick bits the partial remainder is the kept remainder.
        cmd_o.latch_rem = (step_q == ftsched_pkg::STEP_W'(ftsched_pkg::REM_STEP));
        step_d          = step_q + 1'b1;
        if (step_q == ftsched_pkg::STEP_W'(ftsched_pkg::DIV_STEPS - 1)) begin
          state_d = ftsched_pkg::S_WRAP;
        end
      end
      ftsched_pkg::S_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = ftsched_pkg::S_TOTAL;
      end
      ftsched_pkg::S_TOTAL: begin
        cmd_o.totals = 1'b1;
        cmd_o.sim_lo = (stat_i.route == ftsched_pkg::ROUTE_TICKS);
        state_d      = ftsched_pkg::S_OUT;
      end
      ftsched_pkg::S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ftsched_pkg::S_IDLE;
        end
      end
      default: state_d = ftsched_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/ftsched_dp.sv
// Datapath of the fixed-step tick scheduler: frame capture, shared multiplier, serial
// restoring divider, accumulators, drop counters and the output register. Uses ftsched_pkg.
`default_nettype none

module ftsched_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire ftsched_pkg::cmd_t                 cmd_i,
  output ftsched_pkg::stat_t                     stat_o,
  input  wire logic [ftsched_pkg::TI_W-1:0]      tick_interval_i,
  input  wire logic [ftsched_pkg::MS_W-1:0]      max_steps_i,
  input  wire logic                              clear_i,
  input  wire logic                              scene_mode_i,
  input  wire logic                              scene_physics_on_i,
  input  wire logic [1:0]                        advance_state_i,
  input  wire logic                              step_held_i,
  input  wire logic                              step_allowed_i,
  input  wire logic                              lockstep_mode_i,
  input  wire logic [ftsched_pkg::FT_W-1:0]      frame_time_i,
  input  wire logic [ftsched_pkg::TS_W-1:0]      speed_scale_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic                                   update_logic_o,
  output logic [ftsched_pkg::MS_W-1:0]           committed_ticks_o,
  output logic [ftsched_pkg::REQ_W-1:0]          dropped_ticks_o,
  output logic [ftsched_pkg::FT_W-1:0]           camera_dt_o,
  output logic [ftsched_pkg::SIM_W-1:0]          simulation_dt_o,
  output logic [ftsched_pkg::ALPHA_W-1:0]        blend_alpha_o,
  output logic [ftsched_pkg::CNT_W-1:0]          dropped_total_o,
  output logic [ftsched_pkg::CNT_W-1:0]          hitch_total_o
);

  localparam int unsigned FT_W    = ftsched_pkg::FT_W;
  localparam int unsigned TS_W    = ftsched_pkg::TS_W;
  localparam int unsigned TI_W    = ftsched_pkg::TI_W;
  localparam int unsigned MS_W    = ftsched_pkg::MS_W;
  localparam int unsigned PROD_W  = ftsched_pkg::PROD_W;
  localparam int unsigned SIM_W   = ftsched_pkg::SIM_W;
  localparam int unsigned SUM_W   = ftsched_pkg::SUM_W;
  localparam int unsigned FRAC_W  = ftsched_pkg::FRAC_W;
  localparam int unsigned QUO_W   = ftsched_pkg::QUO_W;
  localparam int unsigned REQ_W   = ftsched_pkg::REQ_W;
  localparam int unsigned ALPHA_W = ftsched_pkg::ALPHA_W;
  localparam int unsigned CNT_W   = ftsched_pkg::CNT_W;
  localparam int unsigned LREQ_W  = ftsched_pkg::LREQ_W;

  // Captured frame.
  logic            scene_q, phys_q, step_q, lock_q;
  logic [FT_W-1:0] ft_q;
  logic [TS_W-1:0] ts_q;

  // Scheduler state.
  logic [TI_W-1:0]   wacc_q, wacc_d;
  logic [FRAC_W-1:0] lacc_q, lacc_d;
  logic [CNT_W-1:0]  dcnt_q, dcnt_d;
  logic [CNT_W-1:0]  hcnt_q, hcnt_d;

  // Working registers.
  logic [PROD_W-1:0] prod_q;
  logic [QUO_W-1:0]  dq_q;
  logic [TI_W-1:0]   rem_q;

  // Frame result.
  logic               upd_q;
  logic [MS_W-1:0]    comm_q;
  logic [REQ_W-1:0]   drop_q;
  logic [FT_W-1:0]    cam_q;
  logic [SIM_W-1:0]   sim_q;
  logic [ALPHA_W-1:0] alpha_q;

  logic out_valid_q;

  logic [TI_W-1:0]   ti_eff;
  logic              stepping;
  logic              phys_off;
  logic              lock_step;
  logic [TI_W-1:0]   mul_a;
  logic [TS_W-1:0]   mul_b;
  logic [SUM_W-1:0]  wsum;
  logic [TS_W:0]     lsum;
  logic [LREQ_W-1:0] lreq, lcomm, ldrop;
  logic [TI_W:0]     trial;
  logic              trial_ge;
  logic [SUM_W-1:0]  req_full;
  logic [REQ_W-1:0]  req_sat, max_ext, wcomm, wdrop;

  assign ti_eff   = (tick_interval_i == '0) ? TI_W'(1) : tick_interval_i;
  assign stepping = ((advance_state_i == 2'd1) || ((advance_state_i == 2'd2) && step_held_i))
                    && step_allowed_i;
  assign phys_off = scene_q & ~phys_q;
  assign lock_step = ~phys_off & lock_q & step_q;

  always_comb begin
    stat_o.out_free = ~out_valid_q | out_ready_i;
    if (phys_off || !step_q) begin
      stat_o.route = ftsched_pkg::ROUTE_FINISH;
    end else if (lock_q) begin
      stat_o.route = ftsched_pkg::ROUTE_TICKS;
    end else begin
      stat_o.route = ftsched_pkg::ROUTE_DIVIDE;
    end
  end

  // One multiplier serves scaled time, tick time scale and ticks times interval.
  assign mul_a = (cmd_i.mul_tick || lock_q) ? ti_eff : ft_q;
  assign mul_b = cmd_i.mul_tick ? TS_W'(comm_q) : ts_q;

  assign wsum = SUM_W'(wacc_q) + SUM_W'(prod_q[PROD_W-1:FRAC_W]);
  assign lsum = (TS_W + 1)'(lacc_q) + (TS_W + 1)'(ts_q);
  assign lreq = lsum[TS_W:FRAC_W];
  assign lcomm = (lreq < LREQ_W'(ftsched_pkg::LOCKSTEP_CAP))
                 ? lreq : LREQ_W'(ftsched_pkg::LOCKSTEP_CAP);
  assign ldrop = lreq - lcomm;

  // Restoring division step: one quotient bit per cycle.
  assign trial    = {rem_q, dq_q[QUO_W-1]};
  assign trial_ge = (trial >= (TI_W + 1)'(ti_eff));

  assign req_full = dq_q[QUO_W-1:FRAC_W];
  assign req_sat  = (|req_full[SUM_W-1:REQ_W]) ? ftsched_pkg::TICK_MAX : req_full[REQ_W-1:0];
  assign max_ext  = REQ_W'(max_steps_i);
  assign wcomm    = (req_sat < max_ext) ? req_sat : max_ext;
  assign wdrop    = req_sat - wcomm;

  always_comb begin
    wacc_d = wacc_q;
    lacc_d = lacc_q;
    dcnt_d = dcnt_q;
    hcnt_d = hcnt_q;
    if (cmd_i.capture && clear_i) begin
      wacc_d = '0;
      lacc_d = '0;
      dcnt_d = '0;
      hcnt_d = '0;
    end
    if (cmd_i.prep) begin
      if (phys_off) begin
        wacc_d = '0;
        lacc_d = '0;
      end else if (lock_q) begin
        wacc_d = '0;
        lacc_d = step_q ? lsum[FRAC_W-1:0] : '0;
      end else begin
        lacc_d = '0;
        if (!step_q) begin
          wacc_d = '0;
        end
      end
    end
    if (cmd_i.latch_rem) begin
      wacc_d = rem_q;
    end
    if (cmd_i.totals && (drop_q != '0)) begin
      dcnt_d = dcnt_q + CNT_W'(drop_q);
      hcnt_d = hcnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wacc_q      <= '0;
      lacc_q      <= '0;
      dcnt_q      <= '0;
      hcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wacc_q <= wacc_d;
      lacc_q <= lacc_d;
      dcnt_q <= dcnt_d;
      hcnt_q <= hcnt_d;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      scene_q <= scene_mode_i;
      phys_q  <= scene_physics_on_i;
      step_q  <= stepping;
      lock_q  <= lockstep_mode_i;
      ft_q    <= frame_time_i & ftsched_pkg::FT_MASK;
      ts_q    <= speed_scale_i;
    end
    if (cmd_i.mul_scale || cmd_i.mul_tick) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd_i.prep) begin
      upd_q   <= ~phys_off;
      cam_q   <= phys_off ? '0 : ft_q;
      sim_q   <= phys_off ? '0 : prod_q[PROD_W-1:FRAC_W];
      comm_q  <= lock_step ? MS_W'(lcomm) : '0;
      drop_q  <= lock_step ? REQ_W'(ldrop) : '0;
      alpha_q <= lock_step ? ftsched_pkg::ALPHA_ONE : '0;
      // The fraction bits of the dividend are zero, so the low quotient bits are alpha.
      dq_q  <= {wsum, FRAC_W'(0)};
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dq_q  <= {dq_q[QUO_W-2:0], trial_ge};
      rem_q <= trial_ge ? TI_W'(trial - (TI_W + 1)'(ti_eff)) : trial[TI_W-1:0];
    end
    if (cmd_i.wrap) begin
      comm_q  <= MS_W'(wcomm);
      drop_q  <= wdrop;
      alpha_q <= ALPHA_W'(dq_q[FRAC_W-1:0]);
    end
    if (cmd_i.sim_lo) begin
      sim_q <= prod_q[SIM_W-1:0];
    end
    if (cmd_i.load_out) begin
      update_logic_o    <= upd_q;
      committed_ticks_o <= comm_q;
      dropped_ticks_o   <= drop_q;
      camera_dt_o       <= cam_q;
      simulation_dt_o   <= sim_q;
      blend_alpha_o     <= alpha_q;
      dropped_total_o   <= dcnt_q;
      hitch_total_o     <= hcnt_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### design/fixed_step_tick_scheduler.sv
// Top level of the fixed-step tick scheduler: configuration registers and the
// sequencer and datapath. Depends on ftsched_pkg, ftsched_ctrl and ftsched_dp.
//
// One input transfer per rendered frame yields one result transfer giving the physics
// ticks to run, the ticks dropped by the cap, camera and simulation time, the blend
// fraction and the running drop totals. A wall-clock frame that steps runs the
// 57-step serial restoring divider (one quotient bit per cycle), which yields the tick
// count, the kept remainder and the blend fraction. Lockstep frames that step use a
// second multiply instead, and all other frames skip both.
// The result sits in an output register, so the next frame is accepted while it waits.
// Registers: tick_interval at byte address 0 (zero acts as one), max_steps_per_frame
// at byte address 4 (low 8 bits). Write them only while no frame is in flight.
`default_nettype none

module fixed_step_tick_scheduler (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ftsched_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [ftsched_pkg::DATA_W-1:0]      pwdata,
  output logic [ftsched_pkg::DATA_W-1:0]           prdata,
  output logic                                     pready,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                clear_i,
  input  wire logic                                scene_mode_i,
  input  wire logic                                scene_physics_on_i,
  input  wire logic [1:0]                          advance_state_i,
  input  wire logic                                step_held_i,
  input  wire logic                                step_allowed_i,
  input  wire logic                                lockstep_mode_i,
  input  wire logic [ftsched_pkg::FT_W-1:0]        frame_time_i,
  input  wire logic [ftsched_pkg::TS_W-1:0]        speed_scale_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     update_logic_o,
  output logic [ftsched_pkg::MS_W-1:0]             committed_ticks_o,
  output logic [ftsched_pkg::REQ_W-1:0]            dropped_ticks_o,
  output logic [ftsched_pkg::FT_W-1:0]             camera_dt_o,
  output logic [ftsched_pkg::SIM_W-1:0]            simulation_dt_o,
  output logic [ftsched_pkg::ALPHA_W-1:0]          blend_alpha_o,
  output logic [ftsched_pkg::CNT_W-1:0]            dropped_total_o,
  output logic [ftsched_pkg::CNT_W-1:0]            hitch_total_o
);

  logic [ftsched_pkg::TI_W-1:0] tick_interval_q;
  logic [ftsched_pkg::MS_W-1:0] max_steps_q;
  logic                         cfg_write;
  logic                         reg_sel;
  ftsched_pkg::cmd_t            cmd;
  ftsched_pkg::stat_t           stat;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign reg_sel   = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_interval_q <= ftsched_pkg::TI_W'(279620);
      max_steps_q     <= ftsched_pkg::MS_W'(4);
    end else if (cfg_write) begin
      unique case (reg_sel)
        ftsched_pkg::REG_TICK_INTERVAL: tick_interval_q <= pwdata[ftsched_pkg::TI_W-1:0];
        ftsched_pkg::REG_MAX_STEPS:     max_steps_q     <= pwdata[ftsched_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ftsched_pkg::REG_TICK_INTERVAL: prdata = ftsched_pkg::DATA_W'(tick_interval_q);
      ftsched_pkg::REG_MAX_STEPS:     prdata = ftsched_pkg::DATA_W'(max_steps_q);
      default:                        prdata = '0;
    endcase
  end

  ftsched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ftsched_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .tick_interval_i    (tick_interval_q),
    .max_steps_i        (max_steps_q),
    .clear_i            (clear_i),
    .scene_mode_i       (scene_mode_i),
    .scene_physics_on_i (scene_physics_on_i),
    .advance_state_i    (advance_state_i),
    .step_held_i        (step_held_i),
    .step_allowed_i     (step_allowed_i),
    .lockstep_mode_i    (lockstep_mode_i),
    .frame_time_i       (frame_time_i),
    .speed_scale_i      (speed_scale_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .update_logic_o     (update_logic_o),
    .committed_ticks_o  (committed_ticks_o),
    .dropped_ticks_o    (dropped_ticks_o),
    .camera_dt_o        (camera_dt_o),
    .simulation_dt_o    (simulation_dt_o),
    .blend_alpha_o      (blend_alpha_o),
    .dropped_total_o    (dropped_total_o),
    .hitch_total_o      (hitch_total_o)
  );

endmodule

`default_nettype wire
